// ===== design/fixed_point_alu_checked_assert.svh =====
// assertion macros shared by the checked alu
`ifndef FIXED_POINT_ALU_CHECKED_ASSERT_SVH
`define FIXED_POINT_ALU_CHECKED_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define FPA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define FPA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FPA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FPA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/fpa_pkg.sv =====
package fpa_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int DIV_W = 32 + FRACTION_BITS;
  localparam int NUM_ST = DIV_W + 1;
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_NEG = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_DIVZERO = 2'd3;

  typedef enum logic [2:0] {
    KIND_ADD,
    KIND_SUB,
    KIND_MUL,
    KIND_DIV,
    KIND_NEG,
    KIND_NOP
  } kind_e;

  typedef struct packed {
    logic [2:0]          req_type;
    logic signed [31:0]  operand_a;
    logic signed [31:0]  operand_b;
  } req_t;

  typedef struct packed {
    logic signed [31:0]  result_value;
    logic [1:0]          status_code;
  } rsp_t;

  typedef struct packed {
    kind_e               kind;
    logic signed [31:0]  a;
    logic signed [31:0]  b;
    logic [31:0]         ua;
    logic [31:0]         ub;
    logic                neg;
    logic                dz;
  } q_ent_t;

  typedef struct packed {
    logic                push;
    logic                pop;
    logic [Q_CNT_W-1:0]  cnt;
  } q_stat_t;

  // range check to signed 32 bits, zero result with an error status when out of range
  function automatic rsp_t range_chk(logic signed [63:0] v);
    rsp_t r;
    r.result_value = '0;
    r.status_code = ST_OK;
    if (!v[63] && (v[62:31] != '0)) begin
      r.status_code = ST_OVERFLOW;
    end else if (v[63] && (v[62:31] != '1)) begin
      r.status_code = ST_UNDERFLOW;
    end else begin
      r.result_value = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== design/fixed_point_alu_checked.sv =====
// throughput: one request per cycle while rsp_stall_i is low, set by the one-bit-per-stage divide pipeline
// a two-entry queue parts the request side from the execution pipeline
// reset: rst_ni asynchronous active low, clears queue and pipeline valid bits
`include "fixed_point_alu_checked_assert.svh"
module fixed_point_alu_checked (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_stall_o,
  input  fpa_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_stall_i,
  output fpa_pkg::rsp_t rsp_o
);

  fpa_pkg::q_ent_t  ent, head;
  fpa_pkg::q_stat_t qstat;
  logic full, empty, pop;
  logic rsp_err, cnt_inc, cnt_dec;

  // classify incoming requests
  fpa_front u_front (
    .req_i (req_i),
    .ent_o (ent)
  );

  // request queue between front and back
  fpa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (req_valid_i),
    .ent_i   (ent),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (full),
    .empty_o (empty),
    .stat_o  (qstat)
  );

  assign req_stall_o = full;

  // execution pipeline
  fpa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .rsp_valid_o (rsp_valid_o),
    .rsp_stall_i (rsp_stall_i),
    .rsp_o       (rsp_o)
  );

  // checks
  assign rsp_err = rsp_valid_o && (rsp_o.status_code != fpa_pkg::ST_OK);
  assign cnt_inc = qstat.push && !qstat.pop;
  assign cnt_dec = qstat.pop && !qstat.push;

  `FPA_ASSERT_IMP(a_err_zero, clk_i, rst_ni, rsp_err, rsp_o.result_value == '0)
  `FPA_ASSERT_NXT(a_cnt_up, clk_i, rst_ni, cnt_inc, qstat.cnt == $past(qstat.cnt) + 1'b1)
  `FPA_ASSERT_NXT(a_cnt_dn, clk_i, rst_ni, cnt_dec, qstat.cnt == $past(qstat.cnt) - 1'b1)

endmodule

// ===== design/fpa_front.sv =====
module fpa_front (
  input  fpa_pkg::req_t   req_i,
  output fpa_pkg::q_ent_t ent_o
);

  // decode the operation and prepare divider operands
  always_comb begin
    ent_o.a = req_i.operand_a;
    ent_o.b = req_i.operand_b;
    ent_o.ua = req_i.operand_a[31] ? 32'(-req_i.operand_a) : req_i.operand_a;
    ent_o.ub = req_i.operand_b[31] ? 32'(-req_i.operand_b) : req_i.operand_b;
    ent_o.neg = req_i.operand_a[31] ^ req_i.operand_b[31];
    ent_o.dz = (req_i.operand_b == '0);
    unique case (req_i.req_type)
      fpa_pkg::OP_ADD: ent_o.kind = fpa_pkg::KIND_ADD;
      fpa_pkg::OP_SUB: ent_o.kind = fpa_pkg::KIND_SUB;
      fpa_pkg::OP_MUL: ent_o.kind = fpa_pkg::KIND_MUL;
      fpa_pkg::OP_DIV: ent_o.kind = fpa_pkg::KIND_DIV;
      fpa_pkg::OP_NEG: ent_o.kind = fpa_pkg::KIND_NEG;
      default:         ent_o.kind = fpa_pkg::KIND_NOP;
    endcase
  end

endmodule

// ===== design/fpa_queue.sv =====
module fpa_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fpa_pkg::q_ent_t  ent_i,
  input  logic             pop_i,
  output fpa_pkg::q_ent_t  head_o,
  output logic             full_o,
  output logic             empty_o,
  output fpa_pkg::q_stat_t stat_o
);

  fpa_pkg::q_ent_t mem_q [fpa_pkg::Q_DEPTH];
  logic [fpa_pkg::Q_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [fpa_pkg::Q_CNT_W-1:0] cnt_q, cnt_d;
  logic do_push, do_pop;

  assign full_o = (cnt_q == fpa_pkg::Q_CNT_W'(fpa_pkg::Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign head_o = mem_q[rd_q];

  // pointer and fill count update
  always_comb begin
    wr_d = do_push ? wr_q + 1'b1 : wr_q;
    rd_d = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_q <= wr_d;
      rd_q <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= ent_i;
    end
  end

  assign stat_o.push = do_push;
  assign stat_o.pop = do_pop;
  assign stat_o.cnt = cnt_q;

endmodule

// ===== design/fpa_back.sv =====
module fpa_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fpa_pkg::q_ent_t head_i,
  input  logic            empty_i,
  output logic            pop_o,
  output logic            rsp_valid_o,
  input  logic            rsp_stall_i,
  output fpa_pkg::rsp_t   rsp_o
);

  localparam int NS = fpa_pkg::NUM_ST;
  localparam int DW = fpa_pkg::DIV_W;

  logic                vld_q  [NS];
  fpa_pkg::kind_e      kind_q [NS];
  fpa_pkg::rsp_t       res_q  [NS];
  logic                neg_q  [NS];
  logic                dz_q   [NS];
  logic [31:0]         ub_q   [NS];
  logic [31:0]         rem_q  [NS];
  logic [DW-1:0]       dvd_q  [NS];
  logic [DW-1:0]       quo_q  [NS];
  logic [31:0]         rem_d  [NS];
  logic [NS-1:0]       qbit_d;
  logic signed [63:0]  val_q, val_d;
  fpa_pkg::rsp_t       res1_d, fin_d, out_q;
  logic                out_vld_q, adv;
  logic [32:0]         r33 [NS];
  logic signed [63:0]  shv;
  logic [DW-1:0]       qf;

  assign adv = !out_vld_q || !rsp_stall_i;
  assign pop_o = adv && !empty_i;

  // stage zero arithmetic: sum, difference, negation or product
  always_comb begin
    case (head_i.kind)
      fpa_pkg::KIND_ADD: val_d = 64'(head_i.a) + 64'(head_i.b);
      fpa_pkg::KIND_SUB: val_d = 64'(head_i.a) - 64'(head_i.b);
      fpa_pkg::KIND_MUL: val_d = head_i.a * head_i.b;
      fpa_pkg::KIND_NEG: val_d = -64'(head_i.a);
      default:           val_d = '0;
    endcase
  end

  // stage one scaling and range check for non-divide work
  always_comb begin
    shv = (kind_q[0] == fpa_pkg::KIND_MUL) ? (val_q >>> fpa_pkg::FRACTION_BITS) : val_q;
    res1_d = fpa_pkg::range_chk(shv);
  end

  // one restoring divide step per stage
  always_comb begin
    r33[0] = '0;
    rem_d[0] = '0;
    qbit_d[0] = 1'b0;
    for (int s = 1; s < NS; s++) begin
      r33[s] = {rem_q[s-1], dvd_q[s-1][DW-1]};
      qbit_d[s] = (r33[s] >= {1'b0, ub_q[s-1]});
      rem_d[s] = qbit_d[s] ? 32'(r33[s] - {1'b0, ub_q[s-1]}) : r33[s][31:0];
    end
  end

  // final selection with quotient range check
  always_comb begin
    qf = quo_q[NS-1];
    fin_d = res_q[NS-1];
    if (kind_q[NS-1] == fpa_pkg::KIND_DIV) begin
      fin_d.result_value = '0;
      if (dz_q[NS-1]) begin
        fin_d.status_code = fpa_pkg::ST_DIVZERO;
      end else if (neg_q[NS-1]) begin
        if (qf > DW'(64'h8000_0000)) begin
          fin_d.status_code = fpa_pkg::ST_UNDERFLOW;
        end else begin
          fin_d.status_code = fpa_pkg::ST_OK;
          fin_d.result_value = 32'(-qf);
        end
      end else begin
        if (qf > DW'(64'h7FFF_FFFF)) begin
          fin_d.status_code = fpa_pkg::ST_OVERFLOW;
        end else begin
          fin_d.status_code = fpa_pkg::ST_OK;
          fin_d.result_value = qf[31:0];
        end
      end
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NS; s++) begin
        vld_q[s] <= 1'b0;
      end
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= pop_o;
      for (int s = 1; s < NS; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
      out_vld_q <= vld_q[NS-1];
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind_q[0] <= head_i.kind;
      val_q <= val_d;
      res_q[0] <= '0;
      neg_q[0] <= head_i.neg;
      dz_q[0] <= head_i.dz;
      ub_q[0] <= head_i.ub;
      rem_q[0] <= '0;
      dvd_q[0] <= DW'(head_i.ua) << fpa_pkg::FRACTION_BITS;
      quo_q[0] <= '0;
      for (int s = 1; s < NS; s++) begin
        kind_q[s] <= kind_q[s-1];
        res_q[s] <= (s == 1) ? res1_d : res_q[s-1];
        neg_q[s] <= neg_q[s-1];
        dz_q[s] <= dz_q[s-1];
        ub_q[s] <= ub_q[s-1];
        rem_q[s] <= rem_d[s];
        dvd_q[s] <= dvd_q[s-1] << 1;
        quo_q[s] <= {quo_q[s-1][DW-2:0], qbit_d[s]};
      end
      out_q <= fin_d;
    end
  end

  assign rsp_valid_o = out_vld_q;
  assign rsp_o = out_q;

endmodule

// ===== tb/fixed_point_alu_checked_monitor.sv =====
module fixed_point_alu_checked_monitor (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  logic           req_stall_i,
  input  fpa_pkg::req_t  req_i,
  input  logic           rsp_valid_i,
  input  logic           rsp_stall_i,
  input  fpa_pkg::rsp_t  rsp_i,
  output int             err_cnt_o,
  output int             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  fpa_pkg::rsp_t expected_rsp_q[$];

  // range check a wide value to signed 32 bits with status, zero result when out of range
  function automatic fpa_pkg::rsp_t clamp_result(logic signed [95:0] v);
    fpa_pkg::rsp_t r;
    r.result_value = '0;
    r.status_code = fpa_pkg::ST_OK;
    if (v > 96'sd2147483647) begin
      r.status_code = fpa_pkg::ST_OVERFLOW;
    end else if (v < -96'sd2147483648) begin
      r.status_code = fpa_pkg::ST_UNDERFLOW;
    end else begin
      r.result_value = v[31:0];
    end
    return r;
  endfunction

  // expected result of one alu request
  function automatic fpa_pkg::rsp_t alu_result(fpa_pkg::req_t rq);
    logic signed [95:0] a;
    logic signed [95:0] b;
    logic signed [95:0] p;
    logic [95:0] ua;
    logic [95:0] ub;
    logic [95:0] q;
    fpa_pkg::rsp_t r;
    a = rq.operand_a;
    b = rq.operand_b;
    r.result_value = '0;
    r.status_code = fpa_pkg::ST_OK;
    case (rq.req_type)
      fpa_pkg::OP_ADD: r = clamp_result(a + b);
      fpa_pkg::OP_SUB: r = clamp_result(a - b);
      fpa_pkg::OP_MUL: begin
        p = a * b;
        r = clamp_result(p >>> fpa_pkg::FRACTION_BITS);
      end
      fpa_pkg::OP_DIV: begin
        if (b == 0) begin
          r.status_code = fpa_pkg::ST_DIVZERO;
        end else begin
          ua = (a < 0) ? -a : a;
          ub = (b < 0) ? -b : b;
          q = (ua << fpa_pkg::FRACTION_BITS) / ub;
          if ((a < 0) != (b < 0)) r = clamp_result(-$signed(q));
          else r = clamp_result($signed(q));
        end
      end
      fpa_pkg::OP_NEG: r = clamp_result(-a);
      default: ;
    endcase
    return r;
  endfunction

  assign pending_o = expected_rsp_q.size();

  // predict on request, compare on response
  always @(posedge clk_i or negedge rst_ni) begin
    fpa_pkg::rsp_t exp_rsp;
    int errs;
    errs = 0;
    if (!rst_ni) begin
      err_cnt_o <= 0;
    end else begin
      if (req_valid_i && !req_stall_i) expected_rsp_q.push_back(alu_result(req_i));
      if (rsp_valid_i && !rsp_stall_i) begin
        if (expected_rsp_q.size() == 0) begin
          $error("unexpected response %h", rsp_i);
          errs++;
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          if (rsp_i.result_value !== exp_rsp.result_value) begin
            $error("result_value exp %h got %h", exp_rsp.result_value, rsp_i.result_value);
            errs++;
          end
          if (rsp_i.status_code !== exp_rsp.status_code) begin
            $error("status_code exp %0d got %0d", exp_rsp.status_code, rsp_i.status_code);
            errs++;
          end
        end
      end
      if (errs != 0) err_cnt_o <= err_cnt_o + errs;
    end
  end
endmodule

// ===== tb/fixed_point_alu_checked_tb.sv =====
module fixed_point_alu_checked_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid = 1'b0;
  logic req_stall;
  fpa_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  fpa_pkg::rsp_t rsp;
  int err_cnt;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_rsp = 1'b0;
  int quiet_cycles = 0;

  always #4 clk_i = ~clk_i;

  fixed_point_alu_checked dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .req_valid_i(req_valid), .req_stall_o(req_stall), .req_i(req),
    .rsp_valid_o(rsp_valid), .rsp_stall_i(rsp_stall), .rsp_o(rsp)
  );

  fixed_point_alu_checked_monitor u_mon (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .req_valid_i(req_valid), .req_stall_i(req_stall), .req_i(req),
    .rsp_valid_i(rsp_valid), .rsp_stall_i(rsp_stall), .rsp_i(rsp),
    .err_cnt_o(err_cnt), .pending_o(pending)
  );

  // receiver stall
  always @(posedge clk_i) begin
    rsp_stall <= hold_rsp || ($urandom_range(99) < stall_pct);
  end

  // watchdog on accepted traffic
  always @(posedge clk_i) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // random operand with a bias toward edge values
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(3)) - 32'd1;
      3: return 32'h0001_0000 * ($urandom_range(1) ? 32'd1 : 32'hffff_ffff);
      4: return 32'($signed(16'($urandom())));
      default: return $urandom();
    endcase
  endfunction

  // present one request and wait for acceptance, valid stays up for the next one
  task automatic send_req(logic [2:0] op, logic [31:0] a, logic [31:0] b);
    if ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    req_valid <= 1'b1;
    req <= '{req_type: op, operand_a: a, operand_b: b};
    do @(posedge clk_i); while (req_stall);
  endtask

  // drop valid after the last request of a burst
  task automatic end_burst();
    req_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_random(int n);
    logic [2:0] op;
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(15) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
      send_req(op, pick_operand(), pick_operand());
    end
    end_burst();
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: edges, every op, special cases
    send_req(fpa_pkg::OP_ADD, 32'h7fff_ffff, 32'h0000_0001);
    send_req(fpa_pkg::OP_ADD, 32'h8000_0000, 32'hffff_ffff);
    send_req(fpa_pkg::OP_ADD, 32'h1234_5678, 32'h0000_1111);
    send_req(fpa_pkg::OP_SUB, 32'h8000_0000, 32'h0000_0001);
    send_req(fpa_pkg::OP_SUB, 32'h7fff_ffff, 32'h8000_0000);
    send_req(fpa_pkg::OP_SUB, 32'h0001_0000, 32'h0002_0000);
    send_req(fpa_pkg::OP_MUL, 32'h0002_0000, 32'h0003_0000);
    send_req(fpa_pkg::OP_MUL, 32'hffff_ffff, 32'h0000_0001);
    send_req(fpa_pkg::OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
    send_req(fpa_pkg::OP_MUL, 32'h8000_0000, 32'h7fff_ffff);
    send_req(fpa_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
    send_req(fpa_pkg::OP_DIV, 32'h0001_0000, 32'h0000_0000);
    send_req(fpa_pkg::OP_DIV, 32'h0003_0000, 32'h0002_0000);
    send_req(fpa_pkg::OP_DIV, 32'hfffd_0000, 32'h0002_0000);
    send_req(fpa_pkg::OP_DIV, 32'h8000_0000, 32'h0001_0000);
    send_req(fpa_pkg::OP_DIV, 32'h8000_0000, 32'hffff_0000);
    send_req(fpa_pkg::OP_DIV, 32'h7fff_ffff, 32'h0000_0001);
    send_req(fpa_pkg::OP_DIV, 32'h8000_0000, 32'h0000_0001);
    send_req(fpa_pkg::OP_NEG, 32'h8000_0000, 32'hffff_ffff);
    send_req(fpa_pkg::OP_NEG, 32'h7fff_ffff, 32'h0);
    send_req(fpa_pkg::OP_NEG, 32'h0, 32'h0);
    send_req(3'd5, 32'hffff_ffff, 32'hffff_ffff);
    send_req(3'd6, 32'h1, 32'h2);
    send_req(3'd7, 32'h8000_0000, 32'h7fff_ffff);
    end_burst();

    // random phases with varied idling and receiver stalls
    send_random(200);
    idle_pct = 51;
    send_random(200);
    drain();
    idle_pct = 0;
    stall_pct = 51;
    send_random(200);
    idle_pct = 36;
    stall_pct = 36;
    send_random(200);

    // long receiver hold-off while requests keep coming
    idle_pct = 0;
    stall_pct = 0;
    fork
      begin
        hold_rsp = 1'b1;
        repeat (150) @(posedge clk_i);
        hold_rsp = 1'b0;
      end
      send_random(120);
    join
    send_random(80);

    drain();
    repeat (70) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+design
design/fpa_pkg.sv
design/fpa_front.sv
design/fpa_queue.sv
design/fpa_back.sv
design/fixed_point_alu_checked.sv
tb/fixed_point_alu_checked_monitor.sv
tb/fixed_point_alu_checked_tb.sv
